/* rtl/gdd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian day difference: shared package
// Widths, item types, calendar tables and constant-division helpers that the
// front and back parts of the day-difference block both use.
// ----------------------------------------------------------------------------
package gdd_pkg;

    // Field widths of the input and result beats.
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 22;

    // Derived internal widths.
    localparam int QUOT_W   = YEAR_W - 2;     // a year divided by four
    localparam int P100_W   = 7;              // (year - 1) / 100 for valid years
    localparam int DOY_W    = 9;              // day of the year, up to 366
    localparam int FRAC_W   = 12;             // p/4 - p/100 + p/400 + day of year
    localparam int SERIAL_W = COUNT_W;        // serial day number

    // Queue depths, both powers of two.
    localparam int MID_DEPTH = 4;
    localparam int MID_AW    = $clog2(MID_DEPTH);
    localparam int MID_CW    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    // Calendar constants.
    localparam int MONTHS = 12;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
    localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR = 22'd365;

    // Division by 25 of a value below 4096.
    // Exact test: q is a multiple of 25 when (q * inverse) mod 4096 <= 163,
    // and the low bits then hold q / 25.
    localparam logic [QUOT_W-1:0] DIV25_INV = 12'd3113;
    localparam logic [QUOT_W-1:0] DIV25_MAX = 12'd163;
    // Quotient: q / 25 == (q * 2622) >> 16 for every q below 4096.
    localparam logic [QUOT_W-1:0] RECIP25       = 12'd2622;
    localparam int                RECIP25_SHIFT = 16;

    // Month lengths of a common year, January first.
    localparam logic [DAY_W-1:0] MONTH_LEN [MONTHS] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Days of a common year that come before each month.
    localparam logic [DOY_W-1:0] DAYS_BEFORE [MONTHS] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // Input beat.
    typedef struct packed {
        logic [DAY_W-1:0]   first_day;
        logic [MONTH_W-1:0] first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MONTH_W-1:0] second_month;
        logic [YEAR_W-1:0]  second_year;
        logic               count_end_day;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               bad_date;
    } out_item_t;

    // One date after classification.
    typedef struct packed {
        logic                p_bad;
        logic [YEAR_W-1:0]   p;       // year - 1
        logic [P100_W-1:0]   p100;    // (year - 1) / 100
        logic [DOY_W-1:0]    doy;     // day of the year, leap day included
    } date_t;

    // Entry of the queue between front and back.
    typedef struct packed {
        date_t a;
        date_t b;
        logic  flag;
    } mid_t;

    // Occupancy of the back part.
    typedef struct packed {
        logic [OUT_CW-1:0] out_count;
        logic [1:0]        in_flight;
    } back_status_t;

    // Length of a month, zero for a month code outside the calendar.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [MONTH_W-1:0] idx;
        logic [DAY_W-1:0]   len;
        idx = month - MONTH_W'(1);
        len = '0;
        if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            len = MONTH_LEN[idx];
        end
        if (month == MONTH_FEB && leap) begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

    // Days before a month in a common year, zero for a bad month code.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
        logic [MONTH_W-1:0] idx;
        logic [DOY_W-1:0]   days;
        idx  = month - MONTH_W'(1);
        days = '0;
        if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            days = DAYS_BEFORE[idx];
        end
        return days;
    endfunction

endpackage
`default_nettype wire

/* rtl/gdd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian day difference: front part
// Accepts date pairs, checks both dates, works out leap years and the
// hundred-year quotients, and stores the classified pair in a short queue.
// ----------------------------------------------------------------------------
module gdd_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire gdd_pkg::in_item_t request,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output gdd_pkg::mid_t         head,
    output logic [gdd_pkg::MID_CW-1:0] level
);
    import gdd_pkg::*;

    // Classify one date: validity, year offset, century quotient, day of year.
    function automatic date_t classify(input logic [DAY_W-1:0]   day,
                                       input logic [MONTH_W-1:0] month,
                                       input logic [YEAR_W-1:0]  year);
        logic [YEAR_W-1:0]   p;
        logic [QUOT_W-1:0]   qy;
        logic [QUOT_W-1:0]   qp;
        logic [2*QUOT_W-1:0] prod_y;
        logic [2*QUOT_W-1:0] prod_p;
        logic [QUOT_W-1:0]   k;
        logic                div4;
        logic                div100;
        logic                leap;
        logic                month_ok;
        logic                year_ok;
        logic                day_ok;
        logic [DAY_W-1:0]    len;
        date_t               r;
        // Leap year: divisible by 4, and not by 100 unless by 400.
        qy     = year[YEAR_W-1:2];
        prod_y = (2*QUOT_W)'(qy) * (2*QUOT_W)'(DIV25_INV);
        k      = prod_y[QUOT_W-1:0];
        div4   = (year[1:0] == 2'b00);
        div100 = div4 && (k <= DIV25_MAX);
        leap   = div4 && (!div100 || (k[1:0] == 2'b00));
        // Range checks.
        month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
        year_ok  = (year != '0) && (year <= YEAR_MAX);
        len      = month_len(month, leap);
        day_ok   = (day != '0) && (day <= len);
        // Whole years before this one and their century count.
        p      = year - YEAR_W'(1);
        qp     = p[YEAR_W-1:2];
        prod_p = (2*QUOT_W)'(qp) * (2*QUOT_W)'(RECIP25);
        r.p_bad = !(month_ok && year_ok && day_ok);
        r.p     = p;
        r.p100  = prod_p[RECIP25_SHIFT+P100_W-1:RECIP25_SHIFT];
        r.doy   = days_before(month) + DOY_W'((month > MONTH_FEB) && leap) + DOY_W'(day);
        return r;
    endfunction

    mid_t              mem_reg [MID_DEPTH];
    logic [MID_AW-1:0] wr_ptr_reg;
    logic [MID_AW-1:0] wr_ptr_next;
    logic [MID_AW-1:0] rd_ptr_reg;
    logic [MID_AW-1:0] rd_ptr_next;
    logic [MID_CW-1:0] count_reg;
    logic [MID_CW-1:0] count_next;
    logic              push_ok;
    logic              pop_ok;
    mid_t              entry;

    // Classify the incoming beat.
    always_comb
    begin
        entry.a    = classify(request.first_day, request.first_month, request.first_year);
        entry.b    = classify(request.second_day, request.second_month, request.second_year);
        entry.flag = request.count_end_day;
    end

    assign full    = (count_reg == MID_CW'(MID_DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];
    assign level   = count_reg;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + MID_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + MID_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok && !pop_ok) begin
            count_next = count_reg + MID_CW'(1);
        end else if (pop_ok && !push_ok) begin
            count_next = count_reg - MID_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule
`default_nettype wire

/* rtl/gdd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Gregorian day difference: back part
// Turns classified date pairs into serial day numbers, takes the absolute
// difference, and holds the results in an output queue.
// ----------------------------------------------------------------------------
module gdd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               mid_empty,
    input  wire gdd_pkg::mid_t      mid_head,
    output logic                    mid_pop,
    output logic                    empty,
    input  wire logic               pop,
    output gdd_pkg::out_item_t      result,
    output gdd_pkg::back_status_t   status
);
    import gdd_pkg::*;

    typedef struct packed {
        logic                p_bad;
        logic                flag;
        logic [SERIAL_W-1:0] year_days_a;
        logic [FRAC_W-1:0]   frac_a;
        logic [SERIAL_W-1:0] year_days_b;
        logic [FRAC_W-1:0]   frac_b;
    } stage1_t;

    typedef struct packed {
        logic                p_bad;
        logic                flag;
        logic [SERIAL_W-1:0] serial_a;
        logic [SERIAL_W-1:0] serial_b;
    } stage2_t;

    // Day count inside the year span, without the 365-per-year part.
    function automatic logic [FRAC_W-1:0] frac_days(input date_t d);
        logic [FRAC_W-1:0] p4;
        logic [FRAC_W-1:0] p100;
        logic [FRAC_W-1:0] p400;
        p4   = FRAC_W'(d.p[YEAR_W-1:2]);
        p100 = FRAC_W'(d.p100);
        p400 = FRAC_W'(d.p100[P100_W-1:2]);
        return p4 - p100 + p400 + FRAC_W'(d.doy);
    endfunction

    stage1_t             s1_reg;
    stage1_t             s1_next;
    logic                s1_valid_reg;
    stage2_t             s2_reg;
    stage2_t             s2_next;
    logic                s2_valid_reg;
    out_item_t           mem_reg [OUT_DEPTH];
    out_item_t           res_next;
    logic [OUT_AW-1:0]   wr_ptr_reg;
    logic [OUT_AW-1:0]   wr_ptr_next;
    logic [OUT_AW-1:0]   rd_ptr_reg;
    logic [OUT_AW-1:0]   rd_ptr_next;
    logic [OUT_CW-1:0]   count_reg;
    logic [OUT_CW-1:0]   count_next;
    logic [OUT_CW:0]     committed;
    logic                issue;
    logic                pop_ok;
    logic [SERIAL_W:0]   a_minus_b;
    logic [SERIAL_W:0]   b_minus_a;
    logic [SERIAL_W-1:0] magnitude;

    // Take a pair from the queue only when the output queue has room for it
    // and for everything already in the pipeline.
    assign committed = (OUT_CW+1)'(count_reg) + (OUT_CW+1)'(s1_valid_reg)
                     + (OUT_CW+1)'(s2_valid_reg);
    assign issue     = !mid_empty && (committed < (OUT_CW+1)'(OUT_DEPTH));
    assign mid_pop   = issue;

    // Stage one: whole-year days and the fractional correction.
    always_comb
    begin
        s1_next.p_bad       = mid_head.a.p_bad || mid_head.b.p_bad;
        s1_next.flag        = mid_head.flag;
        s1_next.year_days_a = SERIAL_W'(mid_head.a.p) * DAYS_PER_YEAR;
        s1_next.frac_a      = frac_days(mid_head.a);
        s1_next.year_days_b = SERIAL_W'(mid_head.b.p) * DAYS_PER_YEAR;
        s1_next.frac_b      = frac_days(mid_head.b);
    end

    // Stage two: serial day numbers.
    always_comb
    begin
        s2_next.p_bad    = s1_reg.p_bad;
        s2_next.flag     = s1_reg.flag;
        s2_next.serial_a = s1_reg.year_days_a + SERIAL_W'(s1_reg.frac_a);
        s2_next.serial_b = s1_reg.year_days_b + SERIAL_W'(s1_reg.frac_b);
    end

    // Stage three: absolute difference plus the end-day flag.
    always_comb
    begin
        a_minus_b = {1'b0, s2_reg.serial_a} - {1'b0, s2_reg.serial_b};
        b_minus_a = {1'b0, s2_reg.serial_b} - {1'b0, s2_reg.serial_a};
        magnitude = a_minus_b[SERIAL_W] ? b_minus_a[SERIAL_W-1:0]
                                        : a_minus_b[SERIAL_W-1:0];
        res_next.bad_date  = s2_reg.p_bad;
        res_next.day_count = s2_reg.p_bad ? '0
                           : COUNT_W'(magnitude + SERIAL_W'(s2_reg.flag));
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        s2_reg <= s2_next;
    end

    // Output queue control.
    assign pop_ok = pop && !empty;
    assign empty  = (count_reg == '0);
    assign result = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = s2_valid_reg ? wr_ptr_reg + OUT_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop_ok ? rd_ptr_reg + OUT_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (s2_valid_reg && !pop_ok) begin
            count_next = count_reg + OUT_CW'(1);
        end else if (pop_ok && !s2_valid_reg) begin
            count_next = count_reg - OUT_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg) begin
            mem_reg[wr_ptr_reg] <= res_next;
        end
    end

    // Occupancy report.
    always_comb
    begin
        status.out_count = count_reg;
        status.in_flight = 2'(s1_valid_reg) + 2'(s2_valid_reg);
    end

endmodule
`default_nettype wire

/* rtl/gregorian_day_difference.sv */
`default_nettype none
// A beat passes through the front queue, the two back pipeline stages and the output queue.
// Throughput: one date pair per cycle; the output queue and a credit count set the pace.
// The front and back queues hold four beats each; the back part stalls once its output
// queue and its two pipeline stages together hold four beats.
// Reset clears the queue pointers, fill counts and pipeline valid bits; storage is not cleared.
// ----------------------------------------------------------------------------
// Gregorian day difference: top level
// Counts the days between two Gregorian dates through a classifying front
// part and a serial-number back part joined by a short queue.
// ----------------------------------------------------------------------------
module gregorian_day_difference (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gdd_pkg::in_item_t  request,
    output logic                    full,
    output logic                    empty,
    input  wire logic               pop,
    output gdd_pkg::out_item_t      result
);
    import gdd_pkg::*;

    mid_t              mid_head;
    logic              mid_empty;
    logic              mid_pop;
    logic [MID_CW-1:0] mid_level;
    back_status_t      back_status;
    logic [OUT_CW:0]   back_total;

    // Front part: check and classify incoming beats.
    gdd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .pop     (mid_pop),
        .empty   (mid_empty),
        .head    (mid_head),
        .level   (mid_level)
    );

    // Back part: serial day numbers, difference and result queue.
    gdd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_head  (mid_head),
        .mid_pop   (mid_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .status    (back_status)
    );

    assign back_total = (OUT_CW+1)'(back_status.out_count)
                      + (OUT_CW+1)'(back_status.in_flight);

    // A flagged date pair never carries a day count.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.bad_date) |-> (result.day_count == '0))
        else $error("bad date result with a nonzero day count");

    // The credit check never lets the output queue overflow.
    a_out_credit: assert property (@(posedge clk) disable iff (!rst_n)
        back_total <= (OUT_CW+1)'(OUT_DEPTH))
        else $error("output queue committed beyond its depth");

    // A beat taken into an empty front queue is there on the next cycle.
    a_front_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full && (mid_level == '0)) |=> (mid_level == MID_CW'(1)))
        else $error("front queue lost an accepted beat");

    // The back part only pulls from the front queue when it holds something.
    a_mid_pop: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> (mid_level != '0))
        else $error("back part popped an empty front queue");

endmodule
`default_nettype wire

/* sim/gregorian_day_difference_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gregorian day difference: testbench
// Feeds date pairs through the queue-style input, pops the counts out under
// random stalls and compares each result beat with a table value or its own
// day-number predictor. A short table of edge and invalid dates runs first,
// then a long random run of mostly well-formed dates with some broken ones.
// ----------------------------------------------------------------------------
module gregorian_day_difference_test;

    import gdd_pkg::*;

    localparam int          RANDOM_BEATS = 1700;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          PRINT_LIMIT  = 40;
    localparam int unsigned LAST_YEAR    = 9999;
    localparam bit          TYPED        = 1'b1;
    localparam bit          PREDICTED    = 1'b0;
    localparam bit          BAD          = 1'b1;
    localparam bit          GOOD         = 1'b0;

    localparam int unsigned COMMON_MONTH_DAYS [12] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };
    localparam int unsigned EDGE_YEARS [12] = '{
        1, 4, 100, 400, 1600, 1700, 1900, 2000, 2100, 2400, 9996, 9999
    };
    localparam int unsigned SHORT_MONTHS [5] = '{2, 4, 6, 9, 11};

    // One row of the directed table.
    typedef struct {
        in_item_t  stim;
        bit        typed;
        out_item_t want;
    } table_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    in_item_t  request;
    logic      full;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t result;

    out_item_t  pending_counts [$];
    table_row_t edge_table [$];
    bit         steady = 1'b0;
    int         mismatches = 0;
    int         cycles = 0;

    gregorian_day_difference DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .request (request),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Calendar arithmetic of the predictor.
    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m < 1 || m > 12)
        begin
            return 0;
        end
        if (m == 2 && is_leap(y))
        begin
            return 29;
        end
        return COMMON_MONTH_DAYS[m-1];
    endfunction

    function automatic bit date_ok(input int unsigned d, input int unsigned m,
                                   input int unsigned y);
        return y >= 1 && y <= LAST_YEAR && d >= 1 && d <= days_in_month(m, y);
    endfunction

    // Day number counted from the first of January of year one.
    function automatic int unsigned day_number(input int unsigned d, input int unsigned m,
                                               input int unsigned y);
        int unsigned past;
        int unsigned total;
        past  = y - 1;
        total = 365 * past + past / 4 - past / 100 + past / 400 + d;
        for (int unsigned k = 1; k < m; k++)
        begin
            total += days_in_month(k, y);
        end
        return total;
    endfunction

    function automatic out_item_t days_between(input in_item_t q);
        out_item_t   r;
        int unsigned a;
        int unsigned b;
        r = '0;
        if (!date_ok(q.first_day, q.first_month, q.first_year) ||
            !date_ok(q.second_day, q.second_month, q.second_year))
        begin
            r.bad_date = 1'b1;
            return r;
        end
        a = day_number(q.first_day, q.first_month, q.first_year);
        b = day_number(q.second_day, q.second_month, q.second_year);
        r.day_count = COUNT_W'(((a > b) ? a - b : b - a) + q.count_end_day);
        return r;
    endfunction

    // Random dates, leaning on century and leap-rule years now and then.
    function automatic int unsigned random_year();
        if ($urandom_range(9) < 2)
        begin
            return EDGE_YEARS[$urandom_range(11)];
        end
        return $urandom_range(LAST_YEAR, 1);
    endfunction

    function automatic void random_day_month(input int unsigned y,
                                             output logic [DAY_W-1:0] d,
                                             output logic [MONTH_W-1:0] m);
        int unsigned len;
        m   = MONTH_W'($urandom_range(12, 1));
        len = days_in_month(m, y);
        d   = DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(len, 1));
    endfunction

    // Spoil one date in one of the ways the block has to catch.
    function automatic void spoil_date(inout logic [DAY_W-1:0] d,
                                       inout logic [MONTH_W-1:0] m,
                                       inout logic [YEAR_W-1:0] y);
        case ($urandom_range(3))
            0:
            begin
                d = '0;
            end
            1:
            begin
                m = MONTH_W'(SHORT_MONTHS[$urandom_range(4)]);
                d = DAY_W'(days_in_month(m, y) + 1);
            end
            2:
            begin
                m = ($urandom_range(1) == 0) ? '0 : MONTH_W'($urandom_range(15, 13));
            end
            default:
            begin
                y = ($urandom_range(1) == 0) ? '0 : YEAR_W'($urandom_range(16383, 10000));
            end
        endcase
    endfunction

    function automatic in_item_t random_request();
        in_item_t    q;
        logic [63:0] raw;
        int unsigned pick;
        int          y2;
        pick = $urandom_range(99);
        // Raw noise over every bit of the beat.
        if (pick >= 85)
        begin
            raw = {$urandom, $urandom};
            q   = raw[$bits(in_item_t)-1:0];
            return q;
        end
        q.count_end_day = $urandom_range(1);
        q.first_year    = YEAR_W'(random_year());
        random_day_month(q.first_year, q.first_day, q.first_month);
        if ($urandom_range(1) == 0)
        begin
            y2 = int'(q.first_year) + int'($urandom_range(2)) - 1;
            if (y2 < 1)
            begin
                y2 = 1;
            end
            if (y2 > int'(LAST_YEAR))
            begin
                y2 = LAST_YEAR;
            end
            q.second_year = YEAR_W'(y2);
        end
        else
        begin
            q.second_year = YEAR_W'(random_year());
        end
        random_day_month(q.second_year, q.second_day, q.second_month);
        if (pick >= 70)
        begin
            if ($urandom_range(1) == 0)
            begin
                spoil_date(q.first_day, q.first_month, q.first_year);
            end
            else
            begin
                spoil_date(q.second_day, q.second_month, q.second_year);
            end
        end
        return q;
    endfunction

    function automatic void add_row(input int unsigned d1, input int unsigned m1,
                                    input int unsigned y1, input int unsigned d2,
                                    input int unsigned m2, input int unsigned y2,
                                    input bit flag, input bit typed,
                                    input int unsigned count, input bit bad);
        table_row_t row;
        row.stim.first_day     = DAY_W'(d1);
        row.stim.first_month   = MONTH_W'(m1);
        row.stim.first_year    = YEAR_W'(y1);
        row.stim.second_day    = DAY_W'(d2);
        row.stim.second_month  = MONTH_W'(m2);
        row.stim.second_year   = YEAR_W'(y2);
        row.stim.count_end_day = flag;
        row.typed              = typed;
        row.want.day_count     = COUNT_W'(count);
        row.want.bad_date      = bad;
        edge_table.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_LIMIT)
        begin
            $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
                     what, cycles, got, want);
        end
        mismatches++;
    endtask

    // Sender side: random idle gaps unless in the steady stretch.
    task automatic idle_gap();
        while (!steady && $urandom_range(99) < 7)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Hold one beat on the input until the block takes it.
    task automatic send_beat(input in_item_t stim, input bit typed, input out_item_t want);
        bit took;
        took = 1'b0;
        push    <= 1'b1;
        request <= stim;
        while (!took)
        begin
            @(negedge clk);
            took = !full;
            @(posedge clk);
        end
        pending_counts.push_back(typed ? want : days_between(stim));
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Receiver side: pop drops about 7 times in a hundred.
    always @(posedge clk)
    begin
        pop <= steady || ($urandom_range(99) >= 7);
    end

    // Result check, sampled mid-cycle on the beat about to be popped.
    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_counts.size() == 0)
            begin
                report_mismatch("unexpected result beat", result.day_count, 0);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (result.day_count !== want.day_count)
                begin
                    report_mismatch("day_count", result.day_count, want.day_count);
                end
                if (result.bad_date !== want.bad_date)
                begin
                    report_mismatch("bad_date", result.bad_date, want.bad_date);
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n   = 1'b0;
        push    = 1'b0;
        request = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Equal dates, the full calendar span, year and leap-day edges.
        add_row( 1,  1,    1,  1,  1,    1, 0, TYPED, 0, GOOD);
        add_row( 1,  1,    1,  1,  1,    1, 1, TYPED, 1, GOOD);
        add_row( 1,  1,    1, 31, 12, 9999, 0, TYPED, 3652058, GOOD);
        add_row(31, 12, 9999,  1,  1,    1, 1, TYPED, 3652059, GOOD);
        add_row(31, 12, 1999,  1,  1, 2000, 0, TYPED, 1, GOOD);
        add_row(28,  2, 2000,  1,  3, 2000, 0, TYPED, 2, GOOD);
        add_row(28,  2, 1900,  1,  3, 1900, 0, TYPED, 1, GOOD);
        add_row(31, 12, 9999, 31, 12, 9998, 0, TYPED, 365, GOOD);
        add_row(29,  2, 2024, 29,  2, 2000, 0, PREDICTED, 0, GOOD);
        add_row(15,  6, 1582,  4,  7, 1776, 1, PREDICTED, 0, GOOD);
        add_row( 1,  3, 2100, 28,  2, 2100, 1, PREDICTED, 0, GOOD);
        // Invalid dates: leap day in a common year, day and month out of range.
        add_row(29,  2, 2023,  1,  1, 2023, 0, TYPED, 0, BAD);
        add_row( 1,  1, 2000, 29,  2, 1900, 1, TYPED, 0, BAD);
        add_row( 0,  1, 2000,  1,  1, 2000, 1, TYPED, 0, BAD);
        add_row(31,  4, 2000,  1,  1, 2000, 0, TYPED, 0, BAD);
        add_row( 1,  0, 2000,  1,  1, 2000, 0, TYPED, 0, BAD);
        add_row( 1,  1, 2000,  1, 13, 2000, 1, TYPED, 0, BAD);
        add_row(31, 15, 16383, 31, 15, 16383, 1, TYPED, 0, BAD);
        // Year zero and years past the last one.
        add_row( 1,  1,    0,  1,  1, 2000, 1, TYPED, 0, BAD);
        add_row( 1,  1, 2000,  1,  1, 10000, 0, TYPED, 0, BAD);

        foreach (edge_table[i])
        begin
            idle_gap();
            send_beat(edge_table[i].stim, edge_table[i].typed, edge_table[i].want);
        end
        hold_until_drained();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            steady = (i >= 400 && i < 800);
            if (i == 1000)
            begin
                hold_until_drained();
            end
            idle_gap();
            send_beat(random_request(), PREDICTED, '0);
        end
        hold_until_drained();
        repeat (8) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
